// File: hdl/hrp_pkg.sv
`timescale 1ns / 1ps
// hrp_pkg: shared types and constants for the http request header parser
// depends on nothing; imported by hrp_engine, http_request_header_parser_core and the testbench
package hrp_pkg;

  localparam int LENGTH_BITS  = 32;
  localparam int VERSION_BITS = 8;
  localparam int KEY_LEN      = 14;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_BITS   = 2 + 3 + 8 + 8 + 1 + 32;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [4:0] {
    ST_METHOD_START = 5'd0,
    ST_METHOD       = 5'd1,
    ST_URI          = 5'd2,
    ST_VH           = 5'd3,
    ST_VT1          = 5'd4,
    ST_VT2          = 5'd5,
    ST_VP           = 5'd6,
    ST_VSLASH       = 5'd7,
    ST_MAJ_START    = 5'd8,
    ST_MAJ          = 5'd9,
    ST_MIN_START    = 5'd10,
    ST_MIN          = 5'd11,
    ST_NL1          = 5'd12,
    ST_LINE_START   = 5'd13,
    ST_LWS          = 5'd14,
    ST_NAME         = 5'd15,
    ST_SPACE        = 5'd16,
    ST_VALUE        = 5'd17,
    ST_NL2          = 5'd18,
    ST_NL3          = 5'd19
  } hrp_state_e;

  typedef enum logic [1:0] {
    VERDICT_MORE = 2'd0,
    VERDICT_DONE = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ROLE_DELIM  = 3'd0,
    ROLE_METHOD = 3'd1,
    ROLE_URI    = 3'd2,
    ROLE_FIRST  = 3'd3,
    ROLE_NAME   = 3'd4,
    ROLE_VALUE  = 3'd5
  } role_e;

  typedef struct packed {
    logic [31:0] length_value;
    logic        length_found;
    logic [7:0]  version_minor;
    logic [7:0]  version_major;
    role_e       byte_role;
    verdict_e    verdict;
  } hrp_result_t;

endpackage

// File: hdl/http_request_header_parser_core.sv
`timescale 1ns / 1ps
// http request head parser: byte input stage, parse engine, result register
// each byte is held in the input stage; its result is then registered in the result stage
// one byte per cycle while the output is not stalled; hrp_engine updates its state once per byte
// a stalled output holds its result while the input stage may still take one more byte
// reset (rst_ni low, asynchronous) empties both stages and returns the parser to method start
// depends on hrp_pkg and hrp_engine
module http_request_header_parser_core
  import hrp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] byte_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] verdict, [4:2] byte_role, [12:5] version_major, [20:13] version_minor,
  // [21] length_found, [53:22] length_value, [55:54] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  hrp_result_t out_q;
  hrp_result_t step_res;
  logic        out_free;
  logic        advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  hrp_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_free) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata[7:0];
    if (advance) out_q <= step_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_q};

  // a byte waiting in the input stage moves on once the output slot frees
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("input stage byte did not reach the output register");

  // backpressure on the input only when both stages hold data
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // a malformed byte carries no role
  a_bad_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.verdict == VERDICT_BAD) |-> (out_q.byte_role == ROLE_DELIM))
    else $error("malformed byte reported with a role");

  // length value is only shown together with the found flag
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.length_found) |-> (out_q.length_value == 32'd0))
    else $error("length value present without length found");

  // a stalled input stage holds its byte until the engine steps on it
  a_step_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("stalled input stage lost its byte");

endmodule

// File: hdl/hrp_engine.sv
`timescale 1ns / 1ps
// hrp_engine: parse state registers and the per-byte step logic
// depends on hrp_pkg
module hrp_engine
  import hrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output hrp_result_t result_o
);

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CTL   = 8'd31;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LOW_C = 8'h63;

  localparam logic [LENGTH_BITS-1:0]  LEN_MAX   = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]  LEN_DIV10 = LEN_MAX / 10;
  localparam logic [3:0]              LEN_MOD10 = 4'(LEN_MAX % 10);
  localparam logic [VERSION_BITS-1:0] VER_MAX   = {VERSION_BITS{1'b1}};
  localparam logic [VERSION_BITS-1:0] VER_DIV10 = VER_MAX / 10;
  localparam logic [3:0]              VER_MOD10 = 4'(VER_MAX % 10);
  localparam logic [3:0]              KEY_END   = 4'(KEY_LEN);

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL) || (c == CH_DEL);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic special;
    case (c) inside
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", 8'h09: special = 1'b1;
      default: special = 1'b0;
    endcase
    return !c[7] && !is_ctl(c) && !special;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] i);
    logic [7:0] k;
    unique case (i)
      4'd0:    k = "c";
      4'd1:    k = "o";
      4'd2:    k = "n";
      4'd3:    k = "t";
      4'd4:    k = "e";
      4'd5:    k = "n";
      4'd6:    k = "t";
      4'd7:    k = "-";
      4'd8:    k = "l";
      4'd9:    k = "e";
      4'd10:   k = "n";
      4'd11:   k = "g";
      4'd12:   k = "t";
      4'd13:   k = "h";
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  function automatic logic [VERSION_BITS-1:0] ver_add(input logic [VERSION_BITS-1:0] v,
                                                      input logic [3:0] d);
    logic [VERSION_BITS-1:0] thr;
    logic [VERSION_BITS+3:0] prod;
    thr  = (d <= VER_MOD10) ? VER_DIV10 : VER_DIV10 - 1'b1;
    prod = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VERSION_BITS{1'b0}}, d};
    return (v > thr) ? VER_MAX : prod[VERSION_BITS-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_add(input logic [LENGTH_BITS-1:0] v,
                                                     input logic [3:0] d);
    logic [LENGTH_BITS-1:0] thr;
    logic [LENGTH_BITS+3:0] prod;
    thr  = (d <= LEN_MOD10) ? LEN_DIV10 : LEN_DIV10 - 1'b1;
    prod = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{LENGTH_BITS{1'b0}}, d};
    return (v > thr) ? LEN_MAX : prod[LENGTH_BITS-1:0];
  endfunction

  hrp_state_e              state_q, state_d;
  logic                    header_seen_q, header_seen_d;
  logic [3:0]              match_idx_q, match_idx_d;
  logic                    pending_q, pending_d;
  logic                    digits_ok_q, digits_ok_d;
  logic                    nonempty_q, nonempty_d;
  logic                    flag_q, flag_d;
  logic [LENGTH_BITS-1:0]  accum_q, accum_d;
  logic [VERSION_BITS-1:0] major_q, major_d;
  logic [VERSION_BITS-1:0] minor_q, minor_d;

  logic       bad;
  logic       tok, ctl, dig, lws_ch;
  logic [7:0] lc;
  logic [3:0] dval;
  verdict_e   verdict;
  role_e      role;
  logic       found;

  assign tok    = is_token(byte_i);
  assign ctl    = is_ctl(byte_i);
  assign dig    = is_dec(byte_i);
  assign lws_ch = (byte_i == CH_SP) || (byte_i == CH_TAB);
  assign lc     = ((byte_i >= "A") && (byte_i <= "Z")) ? byte_i + 8'd32 : byte_i;
  assign dval   = byte_i[3:0];

  // next state and malformed detection; a bad byte leaves the state alone
  always_comb begin
    bad     = 1'b0;
    state_d = state_q;
    unique case (state_q)
      ST_METHOD_START: begin
        if (!tok) bad = 1'b1;
        else state_d = ST_METHOD;
      end
      ST_METHOD: begin
        if (byte_i == CH_SP) state_d = ST_URI;
        else if (!tok) bad = 1'b1;
      end
      ST_URI: begin
        if (byte_i == CH_SP) state_d = ST_VH;
        else if (ctl) bad = 1'b1;
      end
      ST_VH: begin
        if (byte_i == "H") state_d = ST_VT1;
        else bad = 1'b1;
      end
      ST_VT1: begin
        if (byte_i == "T") state_d = ST_VT2;
        else bad = 1'b1;
      end
      ST_VT2: begin
        if (byte_i == "T") state_d = ST_VP;
        else bad = 1'b1;
      end
      ST_VP: begin
        if (byte_i == "P") state_d = ST_VSLASH;
        else bad = 1'b1;
      end
      ST_VSLASH: begin
        if (byte_i == CH_SLASH) state_d = ST_MAJ_START;
        else bad = 1'b1;
      end
      ST_MAJ_START: begin
        if (dig) state_d = ST_MAJ;
        else bad = 1'b1;
      end
      ST_MAJ: begin
        if (byte_i == CH_DOT) state_d = ST_MIN_START;
        else if (!dig) bad = 1'b1;
      end
      ST_MIN_START: begin
        if (dig) state_d = ST_MIN;
        else bad = 1'b1;
      end
      ST_MIN: begin
        if (byte_i == CH_CR) state_d = ST_NL1;
        else if (!dig) bad = 1'b1;
      end
      ST_NL1: begin
        if (byte_i == CH_LF) state_d = ST_LINE_START;
        else bad = 1'b1;
      end
      ST_LINE_START: begin
        if (byte_i == CH_CR) state_d = ST_NL3;
        else if (header_seen_q && lws_ch) state_d = ST_LWS;
        else if (!tok) bad = 1'b1;
        else state_d = ST_NAME;
      end
      ST_LWS: begin
        if (byte_i == CH_CR) state_d = ST_NL2;
        else if (lws_ch) state_d = ST_LWS;
        else if (ctl) bad = 1'b1;
        else state_d = ST_VALUE;
      end
      ST_NAME: begin
        if (byte_i == CH_COLON) state_d = ST_SPACE;
        else if (!tok) bad = 1'b1;
      end
      ST_SPACE: begin
        if (byte_i == CH_SP) state_d = ST_VALUE;
        else bad = 1'b1;
      end
      ST_VALUE: begin
        if (byte_i == CH_CR) state_d = ST_NL2;
        else if (ctl) bad = 1'b1;
      end
      ST_NL2: begin
        if (byte_i == CH_LF) state_d = ST_LINE_START;
        else bad = 1'b1;
      end
      ST_NL3: begin
        if (byte_i != CH_LF) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
  end

  // datapath updates and per-byte outputs
  always_comb begin
    header_seen_d = header_seen_q;
    match_idx_d   = match_idx_q;
    pending_d     = pending_q;
    digits_ok_d   = digits_ok_q;
    nonempty_d    = nonempty_q;
    flag_d        = flag_q;
    accum_d       = accum_q;
    major_d       = major_q;
    minor_d       = minor_q;
    verdict       = VERDICT_MORE;
    role          = ROLE_DELIM;
    unique case (state_q)
      ST_METHOD_START: begin
        if (tok) role = ROLE_METHOD;
      end
      ST_METHOD: begin
        if (byte_i != CH_SP && tok) role = ROLE_METHOD;
      end
      ST_URI: begin
        if (byte_i != CH_SP && !ctl) role = ROLE_URI;
      end
      ST_VSLASH: begin
        if (byte_i == CH_SLASH) begin
          major_d = '0;
          minor_d = '0;
        end
      end
      ST_MAJ_START, ST_MAJ: begin
        if (dig) major_d = ver_add(major_q, dval);
      end
      ST_MIN_START, ST_MIN: begin
        if (dig) minor_d = ver_add(minor_q, dval);
      end
      ST_LINE_START: begin
        if (byte_i != CH_CR && !(header_seen_q && lws_ch) && tok) begin
          header_seen_d = 1'b1;
          match_idx_d   = (lc == CH_LOW_C) ? 4'd1 : 4'd0;
          role          = ROLE_FIRST;
        end
      end
      ST_LWS: begin
        if (byte_i != CH_CR && !lws_ch && !ctl) role = ROLE_VALUE;
      end
      ST_NAME: begin
        if (byte_i == CH_COLON) begin
          if (match_idx_q >= KEY_END) begin
            flag_d      = 1'b1;
            pending_d   = 1'b1;
            digits_ok_d = 1'b1;
            nonempty_d  = 1'b0;
            accum_d     = '0;
          end
        end else if (tok) begin
          role = ROLE_NAME;
          // substring match restarts on a mismatch, counting a fresh 'c'
          if (match_idx_q < KEY_END) begin
            if (lc == key_char(match_idx_q)) match_idx_d = match_idx_q + 4'd1;
            else match_idx_d = (lc == CH_LOW_C) ? 4'd1 : 4'd0;
          end
        end
      end
      ST_VALUE: begin
        if (byte_i == CH_CR) begin
          if (pending_q) begin
            if (!nonempty_q || !digits_ok_q) flag_d = 1'b0;
            pending_d = 1'b0;
          end
        end else if (!ctl) begin
          role = ROLE_VALUE;
          if (pending_q) begin
            nonempty_d = 1'b1;
            if (dig) accum_d = len_add(accum_q, dval);
            else digits_ok_d = 1'b0;
          end
        end
      end
      ST_NL3: begin
        if (byte_i == CH_LF) verdict = VERDICT_DONE;
      end
      default: begin
      end
    endcase
    if (bad) begin
      verdict = VERDICT_BAD;
      role    = ROLE_DELIM;
    end
  end

  assign found = flag_d && !pending_d;

  always_comb begin
    result_o.verdict       = verdict;
    result_o.byte_role     = role;
    result_o.version_major = 8'(major_d);
    result_o.version_minor = 8'(minor_d);
    result_o.length_found  = found;
    result_o.length_value  = found ? 32'(accum_d) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_METHOD_START;
      header_seen_q <= 1'b0;
      match_idx_q   <= '0;
      pending_q     <= 1'b0;
      digits_ok_q   <= 1'b0;
      nonempty_q    <= 1'b0;
      flag_q        <= 1'b0;
      accum_q       <= '0;
      major_q       <= '0;
      minor_q       <= '0;
    end else if (step_i) begin
      state_q       <= state_d;
      header_seen_q <= header_seen_d;
      match_idx_q   <= match_idx_d;
      pending_q     <= pending_d;
      digits_ok_q   <= digits_ok_d;
      nonempty_q    <= nonempty_d;
      flag_q        <= flag_d;
      accum_q       <= accum_d;
      major_q       <= major_d;
      minor_q       <= minor_d;
    end
  end

endmodule

// File: dv/tb_http_request_header_parser_core.sv
`timescale 1ns / 1ps
// tb_http_request_header_parser_core: streams one long http request head, byte by byte,
// into the parser and checks every result transfer against a parse model kept in this file
// depends on hrp_pkg and http_request_header_parser_core
module tb_http_request_header_parser_core
  import hrp_pkg::*;
();

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [7:0]  CH_TAB = 8'h09;
  localparam logic [7:0]  CH_LF  = 8'h0A;
  localparam logic [7:0]  CH_CR  = 8'h0D;
  localparam logic [63:0] LENGTH_MAX = 64'hFFFF_FFFF;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "content-length";

  typedef struct packed {
    hrp_state_e  st;
    logic        hdr_seen;
    logic [4:0]  match_idx;
    logic        pending;
    logic        digits_ok;
    logic        nonempty;
    logic        flag;
    logic [63:0] accum;
    logic [7:0]  major;
    logic [7:0]  minor;
  } parse_ctx_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  parse_ctx_t  parser;
  hrp_result_t parse_results_q[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          noise_en = 1'b0;
  bit          long_hold_req = 1'b0;

  http_request_header_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parse model

  function automatic bit is_ctl(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_special(input logic [7:0] c);
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", CH_TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_token(input logic [7:0] c);
    return (c <= 8'd127) && !is_ctl(c) && !is_special(c);
  endfunction

  function automatic logic [7:0] key_char(input int idx);
    return KEY_TEXT[8*(KEY_LEN-1-idx) +: 8];
  endfunction

  function automatic logic [7:0] version_add(input logic [7:0] v, input logic [7:0] c);
    int unsigned d;
    d = c - "0";
    if (v > (255 - d) / 10) return 8'd255;
    return 8'(v * 10 + d);
  endfunction

  // substring matcher for the length header name, case-insensitive
  function automatic logic [4:0] name_match(input logic [4:0] idx, input logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (idx >= KEY_LEN) return idx;
    if (lc == key_char(idx)) return idx + 5'd1;
    return (lc == "c") ? 5'd1 : 5'd0;
  endfunction

  function automatic hrp_result_t parse_byte(input parse_ctx_t cur, input logic [7:0] c,
                                             output parse_ctx_t nx);
    hrp_result_t r;
    logic        bad;
    logic [63:0] d;
    nx = cur;
    bad = 1'b0;
    r = '0;
    r.verdict = VERDICT_MORE;
    r.byte_role = ROLE_DELIM;
    d = 64'(c - "0");
    case (cur.st)
      ST_METHOD_START: begin
        if (!is_token(c)) bad = 1'b1;
        else begin
          nx.st = ST_METHOD;
          r.byte_role = ROLE_METHOD;
        end
      end
      ST_METHOD: begin
        if (c == " ") nx.st = ST_URI;
        else if (!is_token(c)) bad = 1'b1;
        else r.byte_role = ROLE_METHOD;
      end
      ST_URI: begin
        if (c == " ") nx.st = ST_VH;
        else if (is_ctl(c)) bad = 1'b1;
        else r.byte_role = ROLE_URI;
      end
      ST_VH:  if (c == "H") nx.st = ST_VT1; else bad = 1'b1;
      ST_VT1: if (c == "T") nx.st = ST_VT2; else bad = 1'b1;
      ST_VT2: if (c == "T") nx.st = ST_VP; else bad = 1'b1;
      ST_VP:  if (c == "P") nx.st = ST_VSLASH; else bad = 1'b1;
      ST_VSLASH: begin
        if (c == "/") begin
          nx.major = '0;
          nx.minor = '0;
          nx.st = ST_MAJ_START;
        end else bad = 1'b1;
      end
      ST_MAJ_START: begin
        if (is_dec(c)) begin
          nx.major = version_add(cur.major, c);
          nx.st = ST_MAJ;
        end else bad = 1'b1;
      end
      ST_MAJ: begin
        if (c == ".") nx.st = ST_MIN_START;
        else if (is_dec(c)) nx.major = version_add(cur.major, c);
        else bad = 1'b1;
      end
      ST_MIN_START: begin
        if (is_dec(c)) begin
          nx.minor = version_add(cur.minor, c);
          nx.st = ST_MIN;
        end else bad = 1'b1;
      end
      ST_MIN: begin
        if (c == CH_CR) nx.st = ST_NL1;
        else if (is_dec(c)) nx.minor = version_add(cur.minor, c);
        else bad = 1'b1;
      end
      ST_NL1: if (c == CH_LF) nx.st = ST_LINE_START; else bad = 1'b1;
      ST_LINE_START: begin
        if (c == CH_CR) nx.st = ST_NL3;
        else if (cur.hdr_seen && (c == " " || c == CH_TAB)) nx.st = ST_LWS;
        else if (!is_token(c)) bad = 1'b1;
        else begin
          nx.hdr_seen = 1'b1;
          nx.match_idx = name_match(5'd0, c);
          nx.st = ST_NAME;
          r.byte_role = ROLE_FIRST;
        end
      end
      ST_LWS: begin
        if (c == CH_CR) nx.st = ST_NL2;
        else if (c == " " || c == CH_TAB) nx.st = ST_LWS;
        else if (is_ctl(c)) bad = 1'b1;
        else begin
          nx.st = ST_VALUE;
          r.byte_role = ROLE_VALUE;
        end
      end
      ST_NAME: begin
        if (c == ":") begin
          if (cur.match_idx >= KEY_LEN) begin
            nx.flag = 1'b1;
            nx.pending = 1'b1;
            nx.digits_ok = 1'b1;
            nx.nonempty = 1'b0;
            nx.accum = '0;
          end
          nx.st = ST_SPACE;
        end else if (!is_token(c)) bad = 1'b1;
        else begin
          nx.match_idx = name_match(cur.match_idx, c);
          r.byte_role = ROLE_NAME;
        end
      end
      ST_SPACE: if (c == " ") nx.st = ST_VALUE; else bad = 1'b1;
      ST_VALUE: begin
        if (c == CH_CR) begin
          if (cur.pending) begin
            if (!cur.nonempty || !cur.digits_ok) nx.flag = 1'b0;
            nx.pending = 1'b0;
          end
          nx.st = ST_NL2;
        end else if (is_ctl(c)) bad = 1'b1;
        else begin
          r.byte_role = ROLE_VALUE;
          if (cur.pending) begin
            nx.nonempty = 1'b1;
            if (is_dec(c)) begin
              if (cur.accum > (LENGTH_MAX - d) / 10) nx.accum = LENGTH_MAX;
              else nx.accum = cur.accum * 10 + d;
            end else nx.digits_ok = 1'b0;
          end
        end
      end
      ST_NL2: if (c == CH_LF) nx.st = ST_LINE_START; else bad = 1'b1;
      ST_NL3: if (c == CH_LF) r.verdict = VERDICT_DONE; else bad = 1'b1;
      default: bad = 1'b1;
    endcase
    if (bad) begin
      nx = cur;
      r.verdict = VERDICT_BAD;
      r.byte_role = ROLE_DELIM;
    end
    r.version_major = nx.major;
    r.version_minor = nx.minor;
    r.length_found = nx.flag && !nx.pending;
    r.length_value = r.length_found ? nx.accum[31:0] : 32'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] b);
    parse_ctx_t  nx;
    hrp_result_t r;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = parse_byte(parser, b, nx);
    parse_results_q.insert(parse_results_q.size(), r);
    parser = nx;
    bytes_sent++;
  endtask

  // a byte that is malformed in the current parse state, so the walk is not disturbed
  task automatic send_noise();
    logic [7:0]  b;
    parse_ctx_t  scratch;
    hrp_result_t r;
    do begin
      b = 8'($urandom_range(0, 255));
      r = parse_byte(parser, b, scratch);
    end while (r.verdict != VERDICT_BAD);
    send_item(b);
  endtask

  task automatic put(input logic [7:0] b);
    if (noise_en && $urandom_range(0, 9) == 0) send_noise();
    send_item(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (!is_token(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255)); while (b == 8'd127);
    return b;
  endfunction

  task automatic put_digits(input int n);
    for (int i = 0; i < n; i++) put(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_length_name();
    logic [7:0] ch;
    int         name_len;
    case ($urandom_range(0, 5))
      0: put_text("x-");
      1: put_text("co");
      2: repeat ($urandom_range(1, 3)) put(rand_token());
      default: ;
    endcase
    // near miss now and then: one letter short
    name_len = ($urandom_range(0, 7) == 0) ? KEY_LEN - 1 : KEY_LEN;
    for (int i = 0; i < name_len; i++) begin
      ch = key_char(i);
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      put(ch);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) put(rand_token());
  endtask

  task automatic put_header_line();
    int kind;
    int pos;
    int n;
    kind = $urandom_range(0, 9);
    if (kind >= 8 && !parser.hdr_seen) kind = 0;
    if (kind < 4) begin
      put(rand_token());
      repeat ($urandom_range(0, 7)) put(rand_token());
      put_text(": ");
      repeat ($urandom_range(0, 10)) put(rand_value_char());
    end else if (kind < 7) begin
      put_length_name();
      put_text(": ");
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) repeat (n) put("9");
      else put_digits(n);
    end else if (kind < 8) begin
      // length value that must be rejected: empty or with a non-digit
      put_length_name();
      put_text(": ");
      if ($urandom_range(0, 2) != 0) begin
        n = $urandom_range(1, 5);
        pos = $urandom_range(0, n);
        put_digits(pos);
        case ($urandom_range(0, 4))
          0: put(" ");
          1: put("+");
          2: put("-");
          3: put("x");
          default: put(8'($urandom_range(128, 255)));
        endcase
        put_digits(n - pos);
      end
    end else begin
      // continuation of the previous value
      put(($urandom_range(0, 1)) ? " " : CH_TAB);
      repeat ($urandom_range(0, 3)) put(($urandom_range(0, 1)) ? " " : CH_TAB);
      repeat ($urandom_range(0, 6)) put(rand_value_char());
    end
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (parse_results_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_request_line();
    noise_en = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_item(8'h00);
    send_item(8'h80);
    send_item("(");
    put_text("GE");
    send_item(8'hFF);
    put_text("T /");
    send_item(8'hFF);
    send_item(8'h1F);
    put_text(" HTTX");
    put_text("P/2569.01");
    put(CH_CR);
    send_item("x");
    put(CH_LF);
  endtask

  task automatic test_first_header();
    // continuation whitespace is malformed before any header
    send_item(" ");
    put_text("Content-Length: 4294967296");
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic test_random_headers();
    noise_en = 1'b1;
    while (bytes_sent < 780) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      put_header_line();
    end
  endtask

  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    long_hold_req = 1'b1;
    put_text("content-length: 123456");
    put(CH_CR);
    put(CH_LF);
    repeat (4) put_header_line();
  endtask

  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_results_drained();
    repeat (4) put_header_line();
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (bytes_sent < 930) put_header_line();
  endtask

  task automatic test_completion();
    noise_en = 1'b0;
    put(CH_CR);
    send_noise();
    send_item(CH_LF);
    // after completion only a newline is accepted
    repeat (10) begin
      if ($urandom_range(0, 1)) send_item(CH_LF);
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    hrp_result_t got;
    hrp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OUT_BITS-1:0];
      if (parse_results_q.size() == 0) begin
        $error("result transfer with no byte pending");
        errors++;
      end else begin
        want = parse_results_q.pop_front();
        compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
        compare_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
        compare_field("version_major", 32'(want.version_major), 32'(got.version_major));
        compare_field("version_minor", 32'(want.version_minor), 32'(got.version_minor));
        compare_field("length_found", 32'(want.length_found), 32'(got.length_found));
        compare_field("length_value", want.length_value, got.length_value);
        compare_field("pad", 32'd0, 32'(m_axis_tdata[OUT_DATA_W-1:OUT_BITS]));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    parser = '0;
    parser.st = ST_METHOD_START;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_request_line();
    test_first_header();
    test_random_headers();
    test_output_stall();
    test_sender_pause();
    test_no_idle();
    test_completion();
    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (parse_results_q.size() != 0) begin
      $error("%0d results never arrived", parse_results_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
